/* rtl/ffbp_pkg.sv */
// Shared types and constants for the first-fit bin packer.
`timescale 1ns / 1ps
`default_nettype none
package ffbp_pkg;

  localparam int MAX_BINS_DEF = 64;

  localparam int SIZE_W = 16;
  localparam int CAP_W  = 17;
  localparam int HDR_W  = 16;
  localparam int BASE_W = 16;
  localparam int BIN_W  = 17;
  localparam int USED_W = 7;
  localparam int SUM_W  = 18;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 4;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 17'h10000;
  localparam logic [HDR_W-1:0] HEADER_RESET   = 16'h0014;
  localparam logic [SUM_W-1:0] ITEM_OVERHEAD  = 18'd4;

  // lanes are scanned for the first fit in groups of this many
  localparam int GROUP_SIZE = 8;
  localparam int GROUP_W    = 3;

  typedef enum logic [1:0] {
    REG_CAPACITY = 2'd0,
    REG_HEADER   = 2'd1,
    REG_BASE     = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GROUP,
    ST_SELECT,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic load;
    logic group_en;
    logic select_en;
    logic update_en;
  } cmd_t;

  typedef struct packed {
    logic [CAP_W-1:0]  capacity;
    logic [HDR_W-1:0]  header;
    logic [BASE_W-1:0] base;
  } cfg_t;

endpackage
`default_nettype wire

/* rtl/first_fit_bin_packer.sv */
// Top level of the first-fit bin packer.
//
//  channel  handshake             payload
//  -------  --------------------  ------------------------------------------
//  item     start / busy          item_size, last_item
//  result   done (1-cycle strobe) bin_number, placed, bins_used, last_result
//  config   APB psel/penable      paddr, pwdata, prdata, pready
//
// An item is taken when start is high and busy low; its result beat comes on
// done after the compare, group scan, group pick and lane update stages, and
// busy drops in that same cycle so the next item can be taken while the result
// is on the ports. Reset is synchronous; the fill count clears at once, so
// no sweep. There is no output stall: done is high for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_bin_packer #(
  parameter int MAX_BINS = ffbp_pkg::MAX_BINS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [ffbp_pkg::SIZE_W-1:0]  item_size,
  input  wire logic                         last_item,
  output logic                              done,
  output logic      [ffbp_pkg::BIN_W-1:0]   bin_number,
  output logic                              placed,
  output logic      [ffbp_pkg::USED_W-1:0]  bins_used,
  output logic                              last_result,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ffbp_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [ffbp_pkg::DATA_W-1:0]  pwdata,
  output logic      [ffbp_pkg::DATA_W-1:0]  prdata,
  output logic                              pready
);

  ffbp_pkg::cfg_t cfg;
  ffbp_pkg::cmd_t cmd;

  ffbp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ffbp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  ffbp_datapath #(
    .MAX_BINS (MAX_BINS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg         (cfg),
    .item_size   (item_size),
    .last_item   (last_item),
    .done        (done),
    .bin_number  (bin_number),
    .placed      (placed),
    .bins_used   (bins_used),
    .last_result (last_result)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after an item beat");

  a_busy_holds: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |=> busy ##1 busy)
    else $error("busy dropped before the update stage");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("result beat outside the end of an item");

  a_unplaced_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !placed) |-> (bin_number == '0))
    else $error("unplaced item reports a bin number");

endmodule
`default_nettype wire

/* rtl/ffbp_regs.sv */
// APB configuration registers: capacity, header size and bin number base.
`timescale 1ns / 1ps
`default_nettype none
module ffbp_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ffbp_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [ffbp_pkg::DATA_W-1:0]  pwdata,
  output logic      [ffbp_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  output ffbp_pkg::cfg_t                    cfg
);

  ffbp_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = ffbp_pkg::reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capacity <= ffbp_pkg::CAPACITY_RESET;
      cfg.header   <= ffbp_pkg::HEADER_RESET;
      cfg.base     <= '0;
    end else if (wr_en) begin
      unique case (idx)
        ffbp_pkg::REG_CAPACITY: cfg.capacity <= pwdata[ffbp_pkg::CAP_W-1:0];
        ffbp_pkg::REG_HEADER:   cfg.header   <= pwdata[ffbp_pkg::HDR_W-1:0];
        ffbp_pkg::REG_BASE:     cfg.base     <= pwdata[ffbp_pkg::BASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ffbp_pkg::REG_CAPACITY: prdata = ffbp_pkg::DATA_W'(cfg.capacity);
      ffbp_pkg::REG_HEADER:   prdata = ffbp_pkg::DATA_W'(cfg.header);
      ffbp_pkg::REG_BASE:     prdata = ffbp_pkg::DATA_W'(cfg.base);
      default:                prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/ffbp_ctrl.sv */
// Controller: sequences compare, group scan, select and update for one item.
`timescale 1ns / 1ps
`default_nettype none
module ffbp_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  output ffbp_pkg::cmd_t      cmd
);

  ffbp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffbp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    unique case (state)
      ffbp_pkg::ST_IDLE:   state_next = start ? ffbp_pkg::ST_GROUP : ffbp_pkg::ST_IDLE;
      ffbp_pkg::ST_GROUP:  state_next = ffbp_pkg::ST_SELECT;
      ffbp_pkg::ST_SELECT: state_next = ffbp_pkg::ST_UPDATE;
      ffbp_pkg::ST_UPDATE: state_next = ffbp_pkg::ST_IDLE;
      default:             state_next = ffbp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy          = (state != ffbp_pkg::ST_IDLE);
    cmd.load      = (state == ffbp_pkg::ST_IDLE) && start;
    cmd.group_en  = (state == ffbp_pkg::ST_GROUP);
    cmd.select_en = (state == ffbp_pkg::ST_SELECT);
    cmd.update_en = (state == ffbp_pkg::ST_UPDATE);
  end

endmodule
`default_nettype wire

/* rtl/ffbp_datapath.sv */
// Datapath: per-bin fill lanes, fit compare, first-fit pick and result registers.
`timescale 1ns / 1ps
`default_nettype none
module ffbp_datapath #(
  parameter int MAX_BINS = ffbp_pkg::MAX_BINS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire ffbp_pkg::cmd_t               cmd,
  input  wire ffbp_pkg::cfg_t               cfg,
  input  wire logic [ffbp_pkg::SIZE_W-1:0]  item_size,
  input  wire logic                         last_item,
  output logic                              done,
  output logic      [ffbp_pkg::BIN_W-1:0]   bin_number,
  output logic                              placed,
  output logic      [ffbp_pkg::USED_W-1:0]  bins_used,
  output logic                              last_result
);

  localparam int IDX_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CNT_W  = $clog2(MAX_BINS + 1);
  localparam int NGRP   = (MAX_BINS + ffbp_pkg::GROUP_SIZE - 1) / ffbp_pkg::GROUP_SIZE;
  localparam int GI_W   = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int PICK_W = GI_W + ffbp_pkg::GROUP_W;
  localparam int PAD_W  = NGRP * ffbp_pkg::GROUP_SIZE;

  logic [ffbp_pkg::CAP_W-1:0]   fill [MAX_BINS];
  logic [CNT_W-1:0]             used;
  logic [ffbp_pkg::SIZE_W-1:0]  size_r;
  logic                         last_r;
  logic [PAD_W-1:0]             fit;
  logic [PAD_W-1:0]             fit_next;
  logic [NGRP-1:0]              grp_any;
  logic [NGRP-1:0]              grp_any_next;
  logic [ffbp_pkg::GROUP_W-1:0] grp_off [NGRP];
  logic [ffbp_pkg::GROUP_W-1:0] grp_off_next [NGRP];
  logic [IDX_W-1:0]             chosen;
  logic                         found;
  logic [PICK_W-1:0]            pick_next;
  logic                         found_next;
  logic [ffbp_pkg::SUM_W-1:0]   item_add;
  logic [ffbp_pkg::SUM_W-1:0]   item_add_r;
  logic                         empty_fit;
  logic [CNT_W-1:0]             chosen_cnt;
  logic [CNT_W-1:0]             used_next;

  assign item_add   = ffbp_pkg::SUM_W'(item_size) + ffbp_pkg::ITEM_OVERHEAD;
  assign item_add_r = ffbp_pkg::SUM_W'(size_r) + ffbp_pkg::ITEM_OVERHEAD;
  // all bins at or above the used count sit at the header fill
  assign empty_fit  = (ffbp_pkg::SUM_W'(cfg.header) + item_add)
                      <= ffbp_pkg::SUM_W'(cfg.capacity);

  // fit compare, one lane per bin
  always_comb begin
    fit_next = '0;
    for (int k = 0; k < MAX_BINS; k++) begin
      if (CNT_W'(k) < used) begin
        fit_next[k] = (ffbp_pkg::SUM_W'(fill[k]) + item_add)
                      <= ffbp_pkg::SUM_W'(cfg.capacity);
      end else begin
        fit_next[k] = empty_fit;
      end
    end
  end

  // first set bit inside each group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any_next[g] = |fit[g*ffbp_pkg::GROUP_SIZE +: ffbp_pkg::GROUP_SIZE];
      grp_off_next[g] = '0;
      for (int j = ffbp_pkg::GROUP_SIZE - 1; j >= 0; j--) begin
        if (fit[g*ffbp_pkg::GROUP_SIZE + j]) begin
          grp_off_next[g] = ffbp_pkg::GROUP_W'(j);
        end
      end
    end
  end

  // first group with a fit
  always_comb begin
    found_next = |grp_any;
    pick_next  = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        pick_next = {GI_W'(g), grp_off[g]};
      end
    end
  end

  assign chosen_cnt = CNT_W'(chosen) + CNT_W'(1);

  always_comb begin
    used_next = used;
    if (found && (chosen_cnt > used)) begin
      used_next = chosen_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      size_r <= item_size;
      last_r <= last_item;
      fit    <= fit_next;
    end
    if (cmd.group_en) begin
      grp_any <= grp_any_next;
      grp_off <= grp_off_next;
    end
    if (cmd.select_en) begin
      found  <= found_next;
      chosen <= pick_next[IDX_W-1:0];
    end
  end

  for (genvar k = 0; k < MAX_BINS; k++) begin : g_lane
    always_ff @(posedge clk) begin
      if (cmd.update_en && found && (chosen == IDX_W'(k))) begin
        if (CNT_W'(k) < used) begin
          fill[k] <= ffbp_pkg::CAP_W'(ffbp_pkg::SUM_W'(fill[k]) + item_add_r);
        end else begin
          fill[k] <= ffbp_pkg::CAP_W'(ffbp_pkg::SUM_W'(cfg.header) + item_add_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      done <= 1'b0;
    end else begin
      done <= cmd.update_en;
      if (cmd.update_en) begin
        used <= last_r ? '0 : used_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update_en) begin
      bin_number  <= found ? (ffbp_pkg::BIN_W'(cfg.base) + ffbp_pkg::BIN_W'(chosen)) : '0;
      placed      <= found;
      bins_used   <= ffbp_pkg::USED_W'(used_next);
      last_result <= last_r;
    end
  end

endmodule
`default_nettype wire

/* tb/first_fit_bin_packer_test.sv */
// Testbench for the first-fit bin packer: directed rows, then random batches checked by a predictor.
`timescale 1ns / 1ps
module first_fit_bin_packer_test;
  import ffbp_pkg::*;

  localparam int NUM_BINS     = MAX_BINS_DEF;
  localparam int RANDOM_ITEMS = 1850;
  localparam int IDLE_PCT     = 13;
  localparam int SETTLE       = 8;

  typedef struct packed {
    logic [BIN_W-1:0]  bin;
    logic              placed;
    logic [USED_W-1:0] used;
    logic              last;
  } placement_t;

  typedef enum logic { ROW_ITEM, ROW_WRITE } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    reg_idx_t          sel;
    logic [DATA_W-1:0] value;
    logic              last;
    logic              typed;
    placement_t        res;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [SIZE_W-1:0] item_size = '0;
  logic              last_item = 1'b0;
  logic              done;
  logic [BIN_W-1:0]  bin_number;
  logic              placed;
  logic [USED_W-1:0] bins_used;
  logic              last_result;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  first_fit_bin_packer dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item_size(item_size), .last_item(last_item),
    .done(done), .bin_number(bin_number), .placed(placed),
    .bins_used(bins_used), .last_result(last_result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [CAP_W-1:0]  bin_fill [NUM_BINS];
  logic [USED_W-1:0] used_bins;
  logic [CAP_W-1:0]  capacity_cfg;
  logic [HDR_W-1:0]  header_cfg;
  logic [BASE_W-1:0] base_cfg;
  placement_t        pending_placements [$];

  int mismatches = 0;
  int items_sent = 0;
  int reg_writes = 0;
  int placed_seen = 0;
  int missed_seen = 0;
  int max_used_seen = 0;
  int max_bin_seen = 0;
  placement_t head;

  // empty bins (at or above the used count) follow the header
  function automatic void refill_empty_bins();
    for (int k = int'(used_bins); k < NUM_BINS; k++) bin_fill[k] = CAP_W'(header_cfg);
  endfunction

  function automatic placement_t place_item(logic [SIZE_W-1:0] sz, logic lst);
    placement_t r;
    int pick;
    pick = -1;
    for (int k = 0; k < NUM_BINS; k++)
      if (pick < 0 && int'(bin_fill[k]) + int'(ITEM_OVERHEAD) + int'(sz) <= int'(capacity_cfg))
        pick = k;
    r = '0;
    r.last = lst;
    if (pick >= 0) begin
      bin_fill[pick] = CAP_W'(int'(bin_fill[pick]) + int'(ITEM_OVERHEAD) + int'(sz));
      if (pick + 1 > int'(used_bins)) used_bins = USED_W'(pick + 1);
      r.bin = BIN_W'(int'(base_cfg) + pick);
      r.placed = 1'b1;
    end
    r.used = used_bins;
    if (lst) begin
      used_bins = '0;
      refill_empty_bins();
    end
    return r;
  endfunction

  function automatic void check_field(string what, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  function automatic stim_row_t item_row(logic [SIZE_W-1:0] sz, logic lst);
    item_row = '{ROW_ITEM, REG_NONE, DATA_W'(sz), lst, 1'b0, placement_t'(0)};
  endfunction

  function automatic stim_row_t known_row(logic [SIZE_W-1:0] sz, logic lst,
                                          int bin, logic pl, int used);
    known_row = '{ROW_ITEM, REG_NONE, DATA_W'(sz), lst, 1'b1,
                  placement_t'{BIN_W'(bin), pl, USED_W'(used), lst}};
  endfunction

  function automatic stim_row_t write_row(reg_idx_t sel, logic [DATA_W-1:0] v);
    write_row = '{ROW_WRITE, sel, v, 1'b0, 1'b0, placement_t'(0)};
  endfunction

  // result beats: one per accepted item, in order
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_placements.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected, expected none, got bin %0d placed %0d",
                 $time, bin_number, placed);
      end else begin
        head = pending_placements.pop_front();
        check_field("bin_number", head.bin, bin_number);
        check_field("placed", head.placed, placed);
        check_field("bins_used", head.used, bins_used);
        check_field("last_result", head.last, last_result);
      end
      if (placed) begin
        placed_seen++;
        if (int'(bin_number) > max_bin_seen) max_bin_seen = bin_number;
      end else begin
        missed_seen++;
      end
      if (int'(bins_used) > max_used_seen) max_used_seen = bins_used;
    end
  end

  // called right after a rising edge; returns at the edge that takes the beat
  task automatic send_item(logic [SIZE_W-1:0] sz, logic lst, logic typed, placement_t typed_res);
    placement_t p;
    start <= 1'b1;
    item_size <= sz;
    last_item <= lst;
    do @(posedge clk); while (busy);
    p = place_item(sz, lst);
    pending_placements.push_back(typed ? typed_res : p);
    items_sent++;
  endtask

  task automatic maybe_idle(logic quiet);
    if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_placements.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_access(logic wr, reg_idx_t sel, logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {sel, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t sel, logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] rd;
    logic [DATA_W-1:0] want;
    apb_access(1'b1, sel, val, rd);
    reg_writes++;
    want = '0;
    case (sel)
      REG_CAPACITY: begin
        capacity_cfg = val[CAP_W-1:0];
        want = DATA_W'(capacity_cfg);
      end
      REG_HEADER: begin
        header_cfg = val[HDR_W-1:0];
        refill_empty_bins();
        want = DATA_W'(header_cfg);
      end
      REG_BASE: begin
        base_cfg = val[BASE_W-1:0];
        want = DATA_W'(base_cfg);
      end
      default: ;
    endcase
    if (sel != REG_NONE) begin
      apb_access(1'b0, sel, '0, rd);
      check_field("register readback", int'(want), int'(rd));
    end
  endtask

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    stim_row_t   rows [$];
    int unsigned sizes [$];
    int          random_items;
    int          mode;
    int          n;
    int          room;
    int          top;
    int          mid;
    logic        noise;
    logic        lst;

    capacity_cfg = CAPACITY_RESET;
    header_cfg = HEADER_RESET;
    base_cfg = '0;
    used_bins = '0;
    refill_empty_bins();
    random_items = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows = '{
      known_row(16'd0, 1'b0, 0, 1'b1, 1),
      known_row(16'hFFFF, 1'b0, 0, 1'b0, 1),
      known_row(16'd65512, 1'b0, 1, 1'b1, 2),
      item_row(16'h5555, 1'b0),
      item_row(16'hAAAA, 1'b0),
      item_row(16'hFFFF, 1'b1),               // last item that does not fit
      known_row(16'd100, 1'b0, 0, 1'b1, 1),
      write_row(REG_BASE, 32'd65535),
      item_row(16'd1, 1'b0),
      write_row(REG_HEADER, 32'd1000),        // mid-batch: empty bins reload
      item_row(16'd40000, 1'b0),
      item_row(16'd40000, 1'b0),
      write_row(REG_CAPACITY, 32'd10),        // capacity below header
      item_row(16'd0, 1'b0),
      item_row(16'hFFFF, 1'b1),
      known_row(16'd0, 1'b0, 0, 1'b0, 0),
      write_row(REG_CAPACITY, 32'd0),
      write_row(REG_NONE, 32'hFFFF_FFFF),     // unmapped, ignored
      known_row(16'd0, 1'b1, 0, 1'b0, 0),
      write_row(REG_HEADER, 32'd65535),
      write_row(REG_CAPACITY, 32'd65536),
      known_row(16'd0, 1'b0, 0, 1'b0, 0),
      write_row(REG_HEADER, 32'd0),
      known_row(16'd65532, 1'b0, 65535, 1'b1, 1),
      item_row(16'd0, 1'b0),
      item_row(16'd65532, 1'b1),
      write_row(REG_BASE, 32'd0)
    };

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_WRITE) begin
        drain_results();
        write_reg(rows[i].sel, rows[i].value);
      end else begin
        send_item(rows[i].value[SIZE_W-1:0], rows[i].last, rows[i].typed, rows[i].res);
        maybe_idle(1'b0);
      end
    end

    while (random_items < RANDOM_ITEMS) begin
      mode = $urandom_range(99);
      noise = (mode >= 85);
      if (mode < 15) begin
        // crowded batch: room for about one item per bin, can run past the last bin
        drain_results();
        write_reg(REG_HEADER, DATA_W'($urandom_range(0, 2000)));
        write_reg(REG_CAPACITY, DATA_W'(int'(header_cfg) + int'(ITEM_OVERHEAD)
                                        + int'($urandom_range(0, 300))));
        if ($urandom_range(2) == 0)
          write_reg(REG_BASE, $urandom_range(1) ? 32'd65535 : DATA_W'($urandom_range(65535)));
        n = $urandom_range(50, 80);
      end else begin
        if (mode < 45) begin
          drain_results();
          if ($urandom_range(1)) begin
            case ($urandom_range(4))
              0: write_reg(REG_CAPACITY, 32'd65536);
              1: write_reg(REG_CAPACITY, 32'd0);
              2: write_reg(REG_CAPACITY, DATA_W'(int'(header_cfg) + $urandom_range(0, 100)));
              default: write_reg(REG_CAPACITY, DATA_W'($urandom_range(0, 65536)));
            endcase
          end
          if ($urandom_range(1)) begin
            case ($urandom_range(4))
              0: write_reg(REG_HEADER, DATA_W'(HEADER_RESET));
              1: write_reg(REG_HEADER, 32'd0);
              2: write_reg(REG_HEADER, 32'd65535);
              default: write_reg(REG_HEADER, DATA_W'($urandom_range(0, 4000)));
            endcase
          end
          if ($urandom_range(1)) begin
            case ($urandom_range(2))
              0: write_reg(REG_BASE, 32'd0);
              1: write_reg(REG_BASE, 32'd65535);
              default: write_reg(REG_BASE, DATA_W'($urandom_range(65535)));
            endcase
          end
          if ($urandom_range(7) == 0) write_reg(REG_NONE, $urandom());
        end
        n = $urandom_range(1, 40);
      end

      room = int'(capacity_cfg) - int'(header_cfg) - int'(ITEM_OVERHEAD);
      if (mode < 15) top = (room < 0) ? 0 : room;
      else if (noise || room <= 0) top = 65535;
      else top = (room + room / 8 + 2 > 65535) ? 65535 : room + room / 8 + 2;

      sizes.delete();
      repeat (n) sizes.push_back($urandom_range(0, top));
      // largest first, except for noise and a few out-of-order batches
      if (!noise && $urandom_range(9) != 0) sizes.rsort();
      mid = (n > 4 && $urandom_range(9) == 0) ? int'($urandom_range(1, n - 1)) : -1;

      foreach (sizes[i]) begin
        if (i == mid) begin
          drain_results();
          write_reg(REG_HEADER, DATA_W'($urandom_range(0, 3000)));
        end
        lst = (i == n - 1) || (noise && $urandom_range(7) == 0);
        send_item(sizes[i][SIZE_W-1:0], lst, 1'b0, placement_t'(0));
        random_items++;
        maybe_idle(random_items >= 700 && random_items < 1000);
        if (random_items == 1300) drain_results();
      end
    end

    drain_results();
    $display("Sent %0d items with %0d register writes: %0d placed, %0d found no bin.",
             items_sent, reg_writes, placed_seen, missed_seen);
    $display("Most bins in use at once: %0d; highest bin number returned: %0d.",
             max_used_seen, max_bin_seen);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
